// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define WPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication built on the macro above.
`define WPM_ASSERT_IMP(lbl, ante, cons, msg) \
  `WPM_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro.
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `WPM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/wpm_pkg.sv =====
package wpm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int POS_W = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } res_t;

  // ASCII upper-case folding, letters only.
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  // Star closure: an active star position also activates the one after it,
  // through whole runs of stars. The carries of (active&stars)+stars mark
  // exactly the positions reached.
  function automatic logic [POS_W-1:0] close_set(input logic [POS_W-1:0] act,
                                                 input logic [POS_W-1:0] stars);
    logic [POS_W-1:0] gen;
    logic [POS_W-1:0] sum;
    gen = act & stars;
    sum = gen + stars;
    return act | (sum ^ gen ^ stars);
  endfunction

endpackage

// ===== hdl/wpm_cmd_if.sv =====
interface wpm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

// ===== hdl/wpm_res_if.sv =====
interface wpm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== hdl/wildcard_pattern_matcher_unit.sv =====
// Wildcard matcher: '?' takes any one character, '*' any run (also empty),
// anything else must equal the text character after upper-case folding.
//
// cmd channel (valid/ready): opcode + symbol. CLEAR empties the pattern,
// APPEND adds one pattern character (dropped with a sticky overflow flag
// once the store is full), TEXT feeds one text character, END closes the
// text. APPEND and CLEAR also rearm the matcher for a new text.
// res channel (valid/ready): one transaction per END, carrying matched and
// pattern_overflow. No other command produces a result.
//
// A result goes from its END transaction through the input register, then
// the output register, and waits there until taken. Throughput: one command
// every cycle while no END waits on a held result; the next active-position
// vector is combinational (position compares, one star-closure carry add).
// A held result blocks only a following END: text and pattern commands
// keep flowing, and cmd.ready drops only while an END waits behind a
// stalled result.
// Reset (synchronous): empty pattern, flag clear, matcher armed, both
// pipeline registers empty. Pattern store contents are not reset.
module wildcard_pattern_matcher_unit (
  input logic       clk,
  input logic       rst,
  wpm_cmd_if.sink   cmd,
  wpm_res_if.source res
);

  // Input register.
  logic          s1_valid;
  wpm_pkg::cmd_t s1_cmd;
  logic          s1_fire;
  logic          s1_end;

  // Output register.
  logic          res_valid;
  wpm_pkg::res_t res_data;
  wpm_pkg::res_t core_res;

  assign s1_end  = (s1_cmd.opcode == wpm_pkg::OP_END);
  // Only an END needs the output slot.
  assign s1_fire = s1_valid & (~s1_end | ~res_valid | res.ready);

  assign cmd.ready = ~s1_valid | s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd.opcode <= wpm_pkg::opcode_t'(cmd.opcode);
      s1_cmd.symbol <= cmd.symbol;
    end
  end

  wpm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .cmd  (s1_cmd),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_end) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      res_data <= core_res;
    end
  end

  assign res.valid            = res_valid;
  assign res.matched          = res_data.matched;
  assign res.pattern_overflow = res_data.pattern_overflow;

endmodule

// ===== hdl/wpm_core.sv =====
// Pattern store and active-position automaton; one command per fire.
module wpm_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  wpm_pkg::cmd_t cmd,
  output wpm_pkg::res_t res
);

  logic [7:0]                  lit  [wpm_pkg::MAX_PATTERN];
  logic [wpm_pkg::MAX_PATTERN-1:0] star;
  logic [wpm_pkg::MAX_PATTERN-1:0] any_ch;

  logic [wpm_pkg::LEN_W-1:0]   pattern_length;
  logic [wpm_pkg::POS_W-1:0]   active;
  logic [wpm_pkg::POS_W-1:0]   head;
  logic                        overflow;

  logic [wpm_pkg::POS_W-1:0]   star_mask;
  logic [wpm_pkg::MAX_PATTERN-1:0] hit;
  logic [wpm_pkg::MAX_PATTERN-1:0] keep;
  logic [wpm_pkg::POS_W-1:0]   step_set;
  logic [wpm_pkg::POS_W-1:0]   head_grow;
  logic [wpm_pkg::POS_W-1:0]   len_onehot;
  logic [7:0]                  fc;
  logic                        full;
  logic                        sym_star;

  assign fc       = wpm_pkg::fold(cmd.symbol);
  assign full     = (pattern_length == wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN));
  assign sym_star = (cmd.symbol == wpm_pkg::CH_STAR);

  // Per-position transition, only inside the loaded pattern.
  for (genvar i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin : g_pos
    logic in_pat;
    assign in_pat       = (wpm_pkg::LEN_W'(i) < pattern_length);
    assign star_mask[i] = star[i] & in_pat;
    assign keep[i]      = active[i] & star[i] & in_pat;
    assign hit[i]       = active[i] & ~star[i] & in_pat & (any_ch[i] | (lit[i] == fc));
  end
  assign star_mask[wpm_pkg::MAX_PATTERN] = 1'b0;

  assign step_set   = {hit, 1'b0} | {1'b0, keep};
  assign len_onehot = wpm_pkg::POS_W'(1) << pattern_length;
  // Head set grows while the pattern so far is all stars.
  assign head_grow  = (len_onehot << 1) & {wpm_pkg::POS_W{head[pattern_length] & sym_star}};

  assign res.matched          = active[pattern_length];
  assign res.pattern_overflow = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      overflow       <= 1'b0;
      active         <= wpm_pkg::POS_W'(1);
      head           <= wpm_pkg::POS_W'(1);
    end else if (fire) begin
      case (cmd.opcode)
        wpm_pkg::OP_CLEAR: begin
          pattern_length <= '0;
          overflow       <= 1'b0;
          active         <= wpm_pkg::POS_W'(1);
          head           <= wpm_pkg::POS_W'(1);
        end
        wpm_pkg::OP_APPEND: begin
          if (full) begin
            overflow <= 1'b1;
            active   <= head;
          end else begin
            pattern_length <= pattern_length + wpm_pkg::LEN_W'(1);
            head           <= head | head_grow;
            active         <= head | head_grow;
          end
        end
        wpm_pkg::OP_TEXT: begin
          active <= wpm_pkg::close_set(step_set, star_mask);
        end
        default: begin
          active <= head;
        end
      endcase
    end
  end

  // Store entries carry no reset; only entries below the length are read.
  always_ff @(posedge clk) begin
    if (fire && cmd.opcode == wpm_pkg::OP_APPEND && !full) begin
      lit[pattern_length[wpm_pkg::IDX_W-1:0]]    <= fc;
      star[pattern_length[wpm_pkg::IDX_W-1:0]]   <= sym_star;
      any_ch[pattern_length[wpm_pkg::IDX_W-1:0]] <= (cmd.symbol == wpm_pkg::CH_ANY);
    end
  end

endmodule

// ===== hdl/wpm_checker.sv =====
`include "assert_macros.svh"

module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_opcode,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_matched,
  input logic       res_pattern_overflow
);

  // A held result keeps its payload.
  `WPM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_matched) && $stable(res_pattern_overflow), "result changed while stalled")

  // Back-pressure on cmd only comes from a stalled result.
  `WPM_ASSERT_IMP(a_ready_cause, !cmd_ready, res_valid && !res_ready, "cmd stalled without result stall")

  // A fresh result follows an END transaction, through the input and output registers.
  `WPM_ASSERT_IMP(a_res_source, $rose(res_valid), $past(cmd_valid && cmd_ready && (cmd_opcode == wpm_pkg::OP_END), 2), "result without END")

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
  .clk                  (clk),
  .rst                  (rst),
  .cmd_valid            (cmd.valid),
  .cmd_ready            (cmd.ready),
  .cmd_opcode           (cmd.opcode),
  .res_valid            (res.valid),
  .res_ready            (res.ready),
  .res_matched          (res.matched),
  .res_pattern_overflow (res.pattern_overflow)
);
